@@ src/crank_wheel_ignition_scheduler_assert.svh @@
// assertion helpers for the ignition scheduler rtl
`ifndef CRANK_WHEEL_IGNITION_SCHEDULER_ASSERT_SVH
`define CRANK_WHEEL_IGNITION_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CWIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwis: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CWIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwis: next-cycle check failed");

`endif

@@ src/cwis_pkg.sv @@
`default_nettype none

package cwis_pkg;

  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned SUB_W     = 3;
  localparam int unsigned NUM_SLOTS = 4;

  // item operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // coil slot roles
  localparam logic [1:0] SLOT_A_ON  = 2'd0;
  localparam logic [1:0] SLOT_A_OFF = 2'd1;
  localparam logic [1:0] SLOT_B_ON  = 2'd2;
  localparam logic [1:0] SLOT_B_OFF = 2'd3;

  // angle constants in degrees
  localparam logic [ANGLE_W-1:0] TOOTH_DEG        = 9'd6;
  localparam logic [ANGLE_W-1:0] LAST_TOOTH_ANGLE = 9'd348;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF       = 9'd180;
  localparam logic [ANGLE_W-1:0] SLOT1_RST_ANGLE  = 9'd114;
  localparam logic [ANGLE_W-1:0] SLOT3_RST_ANGLE  = 9'd294;
  localparam logic [9:0]         ANGLE_FULL       = 10'd360;
  localparam logic [9:0]         OFF_BASE         = 10'd474;

  // x/6 == (x*171) >> 10 for every x below 360
  localparam logic [7:0] DIV6_RECIP = 8'd171;
  localparam int unsigned DIV6_SHIFT = 10;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [SUB_W-1:0]   sub_t;
  typedef logic [1:0]         slot_id_t;
  typedef logic [1:0]         coils_t;

  // angle split into a tooth boundary and the remainder within the tooth
  typedef struct packed {
    angle_t tooth;
    sub_t   sub;
  } split_t;

  typedef struct packed {
    split_t cur;
    split_t tgt;
  } slot_t;

  // ring entry 0 is always the slot the pointer names
  typedef slot_t [NUM_SLOTS-1:0] ring_t;
  typedef split_t [NUM_SLOTS-1:0] tgt_set_t;

  typedef struct packed {
    ring_t    ring;
    slot_id_t ptr;
    coils_t   coils;
  } slot_ctx_t;

  function automatic split_t split6(angle_t ang);
    logic [16:0] prod;
    logic [5:0]  q;
    angle_t      tooth;
    split_t      res;
    prod      = 17'(ang) * 17'(DIV6_RECIP);
    q         = prod[DIV6_SHIFT+5:DIV6_SHIFT];
    tooth     = ANGLE_W'({q, 2'b00}) + ANGLE_W'({q, 1'b0});
    res.tooth = tooth;
    res.sub   = SUB_W'(ang - tooth);
    return res;
  endfunction

  // floor(x/6) for the small products of sub angle and period remainder
  function automatic logic [2:0] frac6(logic [4:0] x);
    logic [2:0] res;
    case (x) inside
      [5'd0:5'd5]:   res = 3'd0;
      [5'd6:5'd11]:  res = 3'd1;
      [5'd12:5'd17]: res = 3'd2;
      [5'd18:5'd23]: res = 3'd3;
      [5'd24:5'd29]: res = 3'd4;
      default:       res = 3'd5;
    endcase
    return res;
  endfunction

  function automatic coils_t fire_slot(coils_t c, slot_id_t s);
    coils_t res;
    res = c;
    unique case (s)
      SLOT_A_ON:  res[0] = 1'b1;
      SLOT_A_OFF: res[0] = 1'b0;
      SLOT_B_ON:  res[1] = 1'b1;
      SLOT_B_OFF: res[1] = 1'b0;
      default:    res = c;
    endcase
    return res;
  endfunction

  function automatic slot_ctx_t rst_ctx();
    slot_ctx_t res;
    angle_t    init [NUM_SLOTS];
    init[0] = '0;
    init[1] = SLOT1_RST_ANGLE;
    init[2] = ANGLE_HALF;
    init[3] = SLOT3_RST_ANGLE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      res.ring[i].cur.tooth = init[i];
      res.ring[i].cur.sub   = '0;
      res.ring[i].tgt.tooth = init[i];
      res.ring[i].tgt.sub   = '0;
    end
    res.ptr   = '0;
    res.coils = '0;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/cwis_adv_targets.sv @@
`default_nettype none

module cwis_adv_targets import cwis_pkg::*; (
  input  var logic signed [7:0] advance_i,
  input  var slot_id_t          ptr_i,
  output tgt_set_t              tgt_o
);

  logic [9:0] adv_ext;
  logic [9:0] on_raw, off_raw, on_w, off_w, on2_raw, off2_raw, on2_w, off2_w;
  tgt_set_t   abs_tgt;

  // on/off angles from the advance, each folded into one turn
  always_comb begin
    adv_ext  = {{2{advance_i[7]}}, advance_i};
    on_raw   = ANGLE_FULL - adv_ext;
    off_raw  = OFF_BASE - adv_ext;
    on_w     = (on_raw >= ANGLE_FULL) ? on_raw - ANGLE_FULL : on_raw;
    off_w    = (off_raw >= ANGLE_FULL) ? off_raw - ANGLE_FULL : off_raw;
    on2_raw  = on_w + 10'(ANGLE_HALF);
    off2_raw = off_w + 10'(ANGLE_HALF);
    on2_w    = (on2_raw >= ANGLE_FULL) ? on2_raw - ANGLE_FULL : on2_raw;
    off2_w   = (off2_raw >= ANGLE_FULL) ? off2_raw - ANGLE_FULL : off2_raw;
    abs_tgt[SLOT_A_ON]  = split6(on_w[ANGLE_W-1:0]);
    abs_tgt[SLOT_A_OFF] = split6(off_w[ANGLE_W-1:0]);
    abs_tgt[SLOT_B_ON]  = split6(on2_w[ANGLE_W-1:0]);
    abs_tgt[SLOT_B_OFF] = split6(off2_w[ANGLE_W-1:0]);
  end

  // rotate into ring order, entry 0 holds the slot under the pointer
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tgt_o[i] = abs_tgt[slot_id_t'(ptr_i + slot_id_t'(i))];
    end
  end

endmodule

`default_nettype wire

@@ src/cwis_slot_step.sv @@
`default_nettype none

module cwis_slot_step import cwis_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16,
  localparam int unsigned QW = TIMER_BITS - 2
) (
  input  var slot_ctx_t         ctx_i,
  input  var angle_t            angle_i,
  input  var logic [QW-1:0]     per_div_i,
  input  var sub_t              per_rem_i,
  input  var logic [TIMER_BITS-1:0] pend_cmp_i,
  input  var slot_id_t          pend_slot_i,
  input  var logic              pend_armed_i,
  output slot_ctx_t             ctx_o,
  output logic [TIMER_BITS-1:0] pend_cmp_o,
  output slot_id_t              pend_slot_o,
  output logic                  pend_armed_o
);

  localparam int unsigned PW = TIMER_BITS + SUB_W;

  slot_t                 head;
  logic                  hit;
  logic [PW-1:0]         prod;
  logic [4:0]            rprod;
  logic [TIMER_BITS-1:0] delay;

  // delay = period*sub/6, with period held as quotient and remainder by six
  always_comb begin
    head  = ctx_i.ring[0];
    hit   = (head.cur.tooth == angle_i);
    prod  = PW'(per_div_i) * PW'(head.cur.sub);
    rprod = 5'(per_rem_i) * 5'(head.cur.sub);
    delay = prod[TIMER_BITS-1:0] + TIMER_BITS'(frac6(rprod));
  end

  // fire or schedule the head slot, relatch it and rotate the ring
  always_comb begin
    ctx_o        = ctx_i;
    pend_cmp_o   = pend_cmp_i;
    pend_slot_o  = pend_slot_i;
    pend_armed_o = pend_armed_i;
    if (hit) begin
      if (head.cur.sub == '0) begin
        ctx_o.coils = fire_slot(ctx_i.coils, ctx_i.ptr);
      end else begin
        pend_cmp_o   = delay;
        pend_slot_o  = ctx_i.ptr;
        pend_armed_o = 1'b1;
      end
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        ctx_o.ring[i] = ctx_i.ring[i+1];
      end
      ctx_o.ring[NUM_SLOTS-1].cur = head.tgt;
      ctx_o.ring[NUM_SLOTS-1].tgt = head.tgt;
      ctx_o.ptr = ctx_i.ptr + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ src/crank_wheel_ignition_scheduler.sv @@
`default_nettype none

// Decodes a 60-2 crank trigger wheel and schedules two ignition coils. Each input
// transfer is either one timer tick (with an optional rising sensor edge) or a
// load of a new advance in degrees; each input transfer gives exactly one output
// transfer holding coil levels, sync flag, tooth angle and captured period after
// that item. The block takes one item every clock while no held result stalls it:
// an item waits in the input register, and its whole effect on the timers, gap
// and missing-tooth compares and the four-slot coil ring is computed from there
// and written into the state registers that drive the outputs, so a result has
// passed the input register and then the state registers when it is offered.
// Scheduled coil delays of period*sub/6 come from a quotient and remainder by six
// kept alongside the tooth timer, so no divider is needed.
// No clearing pass after reset; the block is ready as soon as reset is released.
module crank_wheel_ignition_scheduler import cwis_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              in_valid_i,
  output logic                  in_stall_o,
  input  var logic              op_i,
  input  var logic              edge_req_i,
  input  var logic signed [7:0] advance_i,
  output logic                  out_valid_o,
  input  var logic              out_stall_i,
  output logic                  coil_a_o,
  output logic                  coil_b_o,
  output logic                  synced_o,
  output logic [8:0]            crank_angle_o,
  output logic [15:0]           tooth_period_o
);

`include "crank_wheel_ignition_scheduler_assert.svh"

  localparam int unsigned TW = TIMER_BITS;
  localparam int unsigned QW = TIMER_BITS - 2;

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic              s1_op_q, s1_edge_q;
  logic signed [7:0] s1_adv_q;
  logic              out_valid_q, out_valid_d;
  logic              adv_en, fire, in_xfer;

  // decoder and scheduler state
  logic [TW-1:0] tt_q, tt_d, phase_q, phase_d, period_q, period_d;
  logic [QW-1:0] tt_div_q, tt_div_d, per_div_q, per_div_d;
  sub_t          tt_rem_q, tt_rem_d, per_rem_q, per_rem_d;
  logic [TW-1:0] gap_cmp_q, gap_cmp_d, pend_cmp_q, pend_cmp_d;
  logic          gap_armed_q, gap_armed_d, sync_q, sync_d;
  logic          t59_q, t59_d, t60_q, t60_d, pend_armed_q, pend_armed_d;
  slot_id_t      pend_slot_q, pend_slot_d;
  angle_t        angle_q, angle_d;
  slot_ctx_t     ctx_q, ctx_d;

  // per-item combinational terms
  logic          is_edge, is_plain, is_load;
  logic [TW-1:0] tt_inc, phase_inc, twice_per;
  logic [TW:0]   gap_sum;
  logic          m_pend, m_ovf, m_gap, m_59, m_60, en_a;
  angle_t        angle_pre, angle_a, angle_b;
  logic [QW-1:0] step_div;
  sub_t          step_rem;
  slot_ctx_t     ctx0, ctx_sa, ctx_a, ctx_sb;
  logic          pend_armed0, pend_armed_sa, pend_armed_a, pend_armed_sb;
  logic [TW-1:0] pend_cmp_sa, pend_cmp_a, pend_cmp_sb;
  slot_id_t      pend_slot_sa, pend_slot_a, pend_slot_sb;
  tgt_set_t      load_tgt;

  // handshake: the state registers double as the output register
  assign adv_en      = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && adv_en;
  assign in_stall_o  = s1_valid_q && !adv_en;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_xfer || (s1_valid_q && !adv_en);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= op_i;
      s1_edge_q <= edge_req_i;
      s1_adv_q  <= advance_i;
    end
  end

  // item decode and compare matches on the counted timers
  always_comb begin
    is_load   = fire && (s1_op_q == OP_LOAD);
    is_edge   = fire && (s1_op_q == OP_TICK) && s1_edge_q;
    is_plain  = fire && (s1_op_q == OP_TICK) && !s1_edge_q;
    tt_inc    = tt_q + TW'(1);
    phase_inc = phase_q + TW'(1);
    twice_per = {period_q[TW-2:0], 1'b0};
    gap_sum   = {tt_q, 1'b0} + {2'b00, tt_q[TW-1:1]};
    m_pend    = is_plain && pend_armed_q && (phase_inc == pend_cmp_q);
    m_ovf     = is_plain && (tt_inc == '0);
    m_gap     = is_plain && gap_armed_q && (tt_inc == gap_cmp_q);
    m_59      = is_plain && t59_q && (tt_inc == period_q);
    m_60      = is_plain && t60_q && (tt_inc == twice_per);
  end

  // pending coil action goes first, then up to two slot steps
  always_comb begin
    ctx0        = ctx_q;
    pend_armed0 = pend_armed_q;
    if (m_pend) begin
      ctx0.coils  = fire_slot(ctx_q.coils, pend_slot_q);
      pend_armed0 = 1'b0;
    end
    angle_pre = (m_ovf || m_gap) ? '0 : angle_q;
    angle_a   = is_edge ? angle_q : angle_pre;
    en_a      = is_edge ? sync_q : m_59;
    step_div  = is_edge ? tt_div_q : per_div_q;
    step_rem  = is_edge ? tt_rem_q : per_rem_q;
  end

  cwis_slot_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step_a (
    .ctx_i        (ctx0),
    .angle_i      (angle_a),
    .per_div_i    (step_div),
    .per_rem_i    (step_rem),
    .pend_cmp_i   (pend_cmp_q),
    .pend_slot_i  (pend_slot_q),
    .pend_armed_i (pend_armed0),
    .ctx_o        (ctx_sa),
    .pend_cmp_o   (pend_cmp_sa),
    .pend_slot_o  (pend_slot_sa),
    .pend_armed_o (pend_armed_sa)
  );

  always_comb begin
    ctx_a        = en_a ? ctx_sa : ctx0;
    pend_cmp_a   = en_a ? pend_cmp_sa : pend_cmp_q;
    pend_slot_a  = en_a ? pend_slot_sa : pend_slot_q;
    pend_armed_a = en_a ? pend_armed_sa : pend_armed0;
    angle_b      = en_a ? angle_a + TOOTH_DEG : angle_a;
  end

  // second step for a tooth 60 match, after any tooth 59 step in the same tick
  cwis_slot_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step_b (
    .ctx_i        (ctx_a),
    .angle_i      (angle_b),
    .per_div_i    (per_div_q),
    .per_rem_i    (per_rem_q),
    .pend_cmp_i   (pend_cmp_a),
    .pend_slot_i  (pend_slot_a),
    .pend_armed_i (pend_armed_a),
    .ctx_o        (ctx_sb),
    .pend_cmp_o   (pend_cmp_sb),
    .pend_slot_o  (pend_slot_sb),
    .pend_armed_o (pend_armed_sb)
  );

  cwis_adv_targets u_targets (
    .advance_i (s1_adv_q),
    .ptr_i     (ctx_q.ptr),
    .tgt_o     (load_tgt)
  );

  // next state
  always_comb begin
    tt_d         = tt_q;
    tt_div_d     = tt_div_q;
    tt_rem_d     = tt_rem_q;
    phase_d      = phase_q;
    period_d     = period_q;
    per_div_d    = per_div_q;
    per_rem_d    = per_rem_q;
    gap_cmp_d    = gap_cmp_q;
    gap_armed_d  = gap_armed_q;
    sync_d       = sync_q;
    t59_d        = t59_q;
    t60_d        = t60_q;
    angle_d      = angle_q;
    ctx_d        = ctx_q;
    pend_cmp_d   = pend_cmp_q;
    pend_slot_d  = pend_slot_q;
    pend_armed_d = pend_armed_q;
    if (is_load) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ctx_d.ring[i].tgt = load_tgt[i];
      end
    end else if (is_edge) begin
      // capture the tooth period and restart both timers
      period_d     = tt_q;
      per_div_d    = tt_div_q;
      per_rem_d    = tt_rem_q;
      tt_d         = '0;
      tt_div_d     = '0;
      tt_rem_d     = '0;
      phase_d      = '0;
      gap_cmp_d    = gap_sum[TW-1:0];
      gap_armed_d  = 1'b1;
      angle_d      = angle_b;
      ctx_d        = ctx_a;
      pend_cmp_d   = pend_cmp_a;
      pend_slot_d  = pend_slot_a;
      pend_armed_d = pend_armed_a;
      if (sync_q && (angle_b == LAST_TOOTH_ANGLE)) begin
        t59_d = 1'b1;
        t60_d = 1'b1;
      end
    end else if (is_plain) begin
      // count, keeping the tooth timer's quotient and remainder by six
      tt_d    = tt_inc;
      phase_d = phase_inc;
      if (tt_inc == '0) begin
        tt_div_d = '0;
        tt_rem_d = '0;
      end else if (tt_rem_q == SUB_W'(5)) begin
        tt_div_d = tt_div_q + QW'(1);
        tt_rem_d = '0;
      end else begin
        tt_rem_d = tt_rem_q + SUB_W'(1);
      end
      if (m_ovf) begin
        sync_d = 1'b0;
      end
      if (m_gap) begin
        sync_d      = 1'b1;
        gap_armed_d = 1'b0;
      end
      if (m_59) begin
        t59_d   = 1'b0;
        phase_d = '0;
      end
      angle_d      = angle_b;
      ctx_d        = ctx_a;
      pend_cmp_d   = pend_cmp_a;
      pend_slot_d  = pend_slot_a;
      pend_armed_d = pend_armed_a;
      if (m_60) begin
        t60_d        = 1'b0;
        tt_d         = '0;
        tt_div_d     = '0;
        tt_rem_d     = '0;
        phase_d      = '0;
        angle_d      = '0;
        ctx_d        = ctx_sb;
        pend_cmp_d   = pend_cmp_sb;
        pend_slot_d  = pend_slot_sb;
        pend_armed_d = pend_armed_sb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_q         <= '0;
      tt_div_q     <= '0;
      tt_rem_q     <= '0;
      phase_q      <= '0;
      period_q     <= '0;
      per_div_q    <= '0;
      per_rem_q    <= '0;
      gap_cmp_q    <= '0;
      gap_armed_q  <= 1'b0;
      sync_q       <= 1'b0;
      t59_q        <= 1'b0;
      t60_q        <= 1'b0;
      angle_q      <= '0;
      ctx_q        <= rst_ctx();
      pend_cmp_q   <= '0;
      pend_slot_q  <= '0;
      pend_armed_q <= 1'b0;
    end else begin
      tt_q         <= tt_d;
      tt_div_q     <= tt_div_d;
      tt_rem_q     <= tt_rem_d;
      phase_q      <= phase_d;
      period_q     <= period_d;
      per_div_q    <= per_div_d;
      per_rem_q    <= per_rem_d;
      gap_cmp_q    <= gap_cmp_d;
      gap_armed_q  <= gap_armed_d;
      sync_q       <= sync_d;
      t59_q        <= t59_d;
      t60_q        <= t60_d;
      angle_q      <= angle_d;
      ctx_q        <= ctx_d;
      pend_cmp_q   <= pend_cmp_d;
      pend_slot_q  <= pend_slot_d;
      pend_armed_q <= pend_armed_d;
    end
  end

  // result ports
  assign out_valid_o    = out_valid_q;
  assign coil_a_o       = ctx_q.coils[0];
  assign coil_b_o       = ctx_q.coils[1];
  assign synced_o       = sync_q;
  assign crank_angle_o  = angle_q;
  assign tooth_period_o = 16'(period_q);

  // input side stalls only behind a held result
  `CWIS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // a staged item reaches the outputs once the result side is free
  `CWIS_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni, s1_valid_q && !(out_valid_o && out_stall_i), out_valid_o)
  // an advance load leaves angle and sync alone
  `CWIS_ASSERT_NEXT(a_load_keeps_angle, clk_i, rst_ni, fire && (s1_op_q == OP_LOAD), (crank_angle_o == $past(crank_angle_o)) && (synced_o == $past(synced_o)))

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cwis_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic        coil_a;
    logic        coil_b;
    logic        synced;
    angle_t      angle;
    logic [15:0] period;
  } crank_status_t;

  // dut ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              op_i        = OP_TICK;
  logic              edge_req_i  = 1'b0;
  logic signed [7:0] advance_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              coil_a_o;
  logic              coil_b_o;
  logic              synced_o;
  logic [8:0]        crank_angle_o;
  logic [15:0]       tooth_period_o;

  crank_wheel_ignition_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .edge_req_i     (edge_req_i),
    .advance_i      (advance_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coil_a_o       (coil_a_o),
    .coil_b_o       (coil_b_o),
    .synced_o       (synced_o),
    .crank_angle_o  (crank_angle_o),
    .tooth_period_o (tooth_period_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted decoder and scheduler state
  logic [15:0] m_tooth_timer, m_phase_timer, m_period, m_gap_cmp, m_pend_cmp;
  logic        m_gap_armed, m_sync, m_t59_armed, m_t60_armed, m_pend_armed;
  angle_t      m_angle;
  logic [1:0]  m_slot_ptr, m_pend_slot, m_coils;
  angle_t      m_slot_tooth [NUM_SLOTS];
  logic [2:0]  m_slot_sub [NUM_SLOTS];
  angle_t      m_slot_target [NUM_SLOTS];

  crank_status_t status_queue [$];
  int unsigned   error_count   = 0;
  int unsigned   items_sent    = 0;
  int unsigned   loads_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   sync_gains    = 0;
  int unsigned   coil_changes  = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   burst_left    = 0;

  function automatic void reset_wheel_model();
    m_tooth_timer = '0;
    m_phase_timer = '0;
    m_period      = '0;
    m_gap_cmp     = '0;
    m_pend_cmp    = '0;
    m_gap_armed   = 1'b0;
    m_sync        = 1'b0;
    m_t59_armed   = 1'b0;
    m_t60_armed   = 1'b0;
    m_pend_armed  = 1'b0;
    m_angle       = '0;
    m_slot_ptr    = '0;
    m_pend_slot   = '0;
    m_coils       = '0;
    m_slot_target[SLOT_A_ON]  = '0;
    m_slot_target[SLOT_A_OFF] = SLOT1_RST_ANGLE;
    m_slot_target[SLOT_B_ON]  = ANGLE_HALF;
    m_slot_target[SLOT_B_OFF] = SLOT3_RST_ANGLE;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m_slot_tooth[i] = m_slot_target[i];
      m_slot_sub[i]   = '0;
    end
  endfunction

  function automatic void drive_coil(logic [1:0] slot);
    case (slot)
      SLOT_A_ON:  m_coils[0] = 1'b1;
      SLOT_A_OFF: m_coils[0] = 1'b0;
      SLOT_B_ON:  m_coils[1] = 1'b1;
      default:    m_coils[1] = 1'b0;
    endcase
  endfunction

  // fire or schedule the slot under the pointer, then latch its new target
  function automatic void step_slot_ring();
    logic [1:0] s;
    s = m_slot_ptr;
    if (m_slot_tooth[s] == m_angle) begin
      if (m_slot_sub[s] == 3'd0) begin
        drive_coil(s);
      end else begin
        m_pend_cmp   = 16'((32'(m_period) * m_slot_sub[s]) / 6);
        m_pend_slot  = s;
        m_pend_armed = 1'b1;
      end
      m_slot_sub[s]   = 3'(m_slot_target[s] % 6);
      m_slot_tooth[s] = m_slot_target[s] - 9'(m_slot_target[s] % 6);
      m_slot_ptr      = s + 2'd1;
    end
  endfunction

  function automatic void step_tooth();
    step_slot_ring();
    m_angle = m_angle + TOOTH_DEG;
  endfunction

  function automatic crank_status_t predict_crank_status(logic op, logic edg,
                                                         logic signed [7:0] adv);
    int            on_deg, off_deg;
    logic          hit_pend, hit_ovf, hit_gap, hit_59, hit_60;
    logic [15:0]   twice_period;
    logic          was_synced;
    logic [1:0]    old_coils;
    crank_status_t res;
    was_synced = m_sync;
    old_coils  = m_coils;
    if (op == OP_LOAD) begin
      // new advance sets all four targets
      on_deg  = (int'(ANGLE_FULL) - int'(adv)) % int'(ANGLE_FULL);
      off_deg = (int'(OFF_BASE) - int'(adv)) % int'(ANGLE_FULL);
      m_slot_target[SLOT_A_ON]  = angle_t'(on_deg);
      m_slot_target[SLOT_A_OFF] = angle_t'(off_deg);
      m_slot_target[SLOT_B_ON]  = angle_t'((on_deg + int'(ANGLE_HALF)) % int'(ANGLE_FULL));
      m_slot_target[SLOT_B_OFF] = angle_t'((off_deg + int'(ANGLE_HALF)) % int'(ANGLE_FULL));
    end else if (edg) begin
      // tooth edge captures the period and restarts the timers
      m_period      = m_tooth_timer;
      m_tooth_timer = '0;
      m_phase_timer = '0;
      m_gap_cmp     = (m_period << 1) + (m_period >> 1);
      m_gap_armed   = 1'b1;
      if (m_sync) begin
        step_tooth();
        if (m_angle == LAST_TOOTH_ANGLE) begin
          m_t59_armed = 1'b1;
          m_t60_armed = 1'b1;
        end
      end
    end else begin
      // plain tick, compares on the new timer values
      m_tooth_timer = m_tooth_timer + 16'd1;
      m_phase_timer = m_phase_timer + 16'd1;
      twice_period  = m_period << 1;
      hit_pend = m_pend_armed && (m_phase_timer == m_pend_cmp);
      hit_ovf  = (m_tooth_timer == 16'd0);
      hit_gap  = m_gap_armed && (m_tooth_timer == m_gap_cmp);
      hit_59   = m_t59_armed && (m_tooth_timer == m_period);
      hit_60   = m_t60_armed && (m_tooth_timer == twice_period);
      if (hit_pend) begin
        drive_coil(m_pend_slot);
        m_pend_armed = 1'b0;
      end
      if (hit_ovf) begin
        m_angle = '0;
        m_sync  = 1'b0;
      end
      if (hit_gap) begin
        m_angle     = '0;
        m_sync      = 1'b1;
        m_gap_armed = 1'b0;
      end
      if (hit_59) begin
        m_t59_armed   = 1'b0;
        m_phase_timer = '0;
        step_tooth();
      end
      if (hit_60) begin
        m_t60_armed   = 1'b0;
        m_tooth_timer = '0;
        m_phase_timer = '0;
        step_tooth();
        m_angle = '0;
      end
    end
    if (!was_synced && m_sync) sync_gains++;
    if (old_coils != m_coils) coil_changes++;
    res.coil_a = m_coils[0];
    res.coil_b = m_coils[1];
    res.synced = m_sync;
    res.angle  = m_angle;
    res.period = m_period;
    return res;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_item(input logic op, input logic edg, input logic signed [7:0] adv);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 2000)
                                               : $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    edge_req_i <= edg;
    advance_i  <= adv;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
    if (op == OP_LOAD) loads_sent++;
    status_queue.push_back(predict_crank_status(op, edg, adv));
  endtask

  task automatic send_tick(input logic edg);
    send_item(OP_TICK, edg, 8'($urandom));
  endtask

  task automatic send_load(input logic signed [7:0] adv);
    send_item(OP_LOAD, 1'($urandom), adv);
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) send_tick(1'b0);
  endtask

  // hold the sender until every expected result has been taken
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_queue.size() != 0);
  endtask

  // every advance extreme, plus a load that carries a stray edge flag
  task automatic test_advance_loads();
    logic signed [7:0] corners [7];
    corners = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1, 8'sd1, 8'sd6, -8'sd6};
    foreach (corners[i]) begin
      send_load(corners[i]);
      send_tick(i[0]);
    end
    send_item(OP_LOAD, 1'b1, 8'sd10);
    wait_until_drained();
  endtask

  // zero period compare, then a long tooth that reaches the gap compare
  task automatic test_timer_extremes();
    send_tick(1'b1);
    send_tick(1'b1);
    run_ticks(40);
    send_tick(1'b1);
    run_ticks(120);
    send_tick(1'b1);
    wait_until_drained();
  endtask

  // sync on a gap, then keep teeth coming so the angle runs past a turn
  task automatic test_angle_wrap();
    send_tick(1'b1);
    run_ticks(2);
    send_tick(1'b1);
    run_ticks(5);
    repeat (90) begin
      run_ticks(2);
      send_tick(1'b1);
    end
    wait_until_drained();
  endtask

  // 60-2 wheel with drifting speed, some broken teeth and advance loads
  task automatic test_wheel_random(input int unsigned n_items);
    int unsigned sent, tooth, spacing, speed;
    sent  = 0;
    speed = $urandom_range(3, 6);
    tooth = $urandom_range(0, 57);
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) speed = $urandom_range(2, 9);
      spacing = (tooth == 0) ? 3 * speed : speed;
      case ($urandom_range(0, 19))
        0:       spacing = $urandom_range(1, 4 * speed);
        1:       spacing = spacing + 1;
        2:       spacing = spacing - 1;
        default: ;
      endcase
      repeat (spacing) begin
        if ($urandom_range(0, 49) == 0) send_load(8'($urandom));
        else send_tick(1'b0);
        sent++;
      end
      send_tick(1'b1);
      sent++;
      tooth = (tooth + 1) % 58;
    end
    wait_until_drained();
  endtask

  // receiver stall pattern, in modes picked at random
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= (stall_phase % 3 == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    crank_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_queue.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        want = status_queue.pop_front();
        results_seen++;
        check_field("coil_a", want.coil_a, coil_a_o);
        check_field("coil_b", want.coil_b, coil_b_o);
        check_field("synced", want.synced, synced_o);
        check_field("crank_angle", want.angle, crank_angle_o);
        check_field("tooth_period", want.period, tooth_period_o);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run limit of %0d cycles reached", CYCLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    reset_wheel_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_advance_loads();
    test_timer_extremes();
    test_angle_wrap();
    test_wheel_random(550);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d items (%0d advance loads), %0d results compared",
             items_sent, loads_sent, results_seen);
    $display("gap sync gained %0d times, coil outputs changed %0d times",
             sync_gains, coil_changes);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
